### hw/rtl/vwap_pkg.sv
// shared types and constants of the vwap accumulator
`timescale 1ns / 1ps

package vwap_pkg;

  localparam int AVG_W     = 47;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 16;
  localparam int QDEPTH    = 4;
  localparam int Q_PTR_W   = $clog2(QDEPTH);
  localparam int LVL_W     = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_DEPTH  = 2'd1;
  localparam logic [1:0] CFG_TARGET = 2'd2;

  typedef enum logic [1:0] {
    MODE_ALL    = 2'd0,
    MODE_DEPTH  = 2'd1,
    MODE_VOLUME = 2'd2
  } weight_mode_e;

  typedef struct packed {
    logic [1:0]  weighting_mode;
    logic [15:0] depth_limit;
    logic [31:0] target_volume;
  } cfg_t;

  typedef struct packed {
    logic [30:0] level_price;
    logic [31:0] level_quantity;
    logic        last_level;
    logic        book_side;
  } in_item_t;

  typedef struct packed {
    logic [46:0] average_price;
    logic [63:0] volume_used;
    logic [15:0] levels_used;
    logic        value_saturated;
    logic        result_side;
  } out_item_t;

  // totals of one finished run, handed from front end to divider
  typedef struct packed {
    logic [SUM_W-1:0] value_sum;
    logic [SUM_W-1:0] volume_sum;
    logic [CNT_W-1:0] level_count;
    logic             saturated;
    logic             side;
  } run_sum_t;

  typedef struct packed {
    logic             empty;
    logic [LVL_W-1:0] level;
  } q_status_t;

endpackage

### hw/rtl/vwap_front.sv
// front end: item admission, quantity clipping, product and run accumulation
`timescale 1ns / 1ps

module vwap_front import vwap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output run_sum_t  push_data_o
);

  // run state that decides admission
  logic [SUM_W-1:0] vol_q, vol_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             lim_q, lim_d;

  // stage 1: admitted item
  logic             s1_valid_q;
  logic             s1_acc_q, s1_last_q, s1_side_q;
  logic [30:0]      s1_price_q;
  logic [31:0]      s1_take_q;
  logic [SUM_W-1:0] s1_vol_q;
  logic [CNT_W-1:0] s1_cnt_q;

  // stage 2: product
  logic             s2_valid_q;
  logic             s2_acc_q, s2_last_q, s2_side_q;
  logic [62:0]      s2_prod_q;
  logic [SUM_W-1:0] s2_vol_q;
  logic [CNT_W-1:0] s2_cnt_q;

  // value accumulator
  logic [SUM_W-1:0] val_q, val_d;
  logic             sat_q, sat_d;

  logic             in_fire;
  logic             accept;
  logic [31:0]      room, take;
  logic [SUM_W:0]   vol_sum;
  logic [SUM_W-1:0] vol_new;
  logic [CNT_W-1:0] cnt_new;
  logic             lim_new;
  logic [LVL_W:0]   credit;
  logic [62:0]      prod;
  logic [SUM_W:0]   val_sum;

  // a run end still in the pipe needs a queue slot later
  assign credit = {1'b0, q_status_i.level}
                + (LVL_W+1)'(s1_valid_q & s1_last_q)
                + (LVL_W+1)'(s2_valid_q & s2_last_q);
  assign in_stall_o = (credit >= (LVL_W+1)'(QDEPTH));
  assign in_fire    = in_valid_i & ~in_stall_o;

  always_comb begin
    case (cfg_i.weighting_mode)
      MODE_DEPTH:  accept = ~lim_q & (cnt_q < cfg_i.depth_limit);
      MODE_VOLUME: accept = ~lim_q & (vol_q < {32'd0, cfg_i.target_volume});
      default:     accept = ~lim_q;
    endcase
    // only used when volume is below target, so upper half is zero
    room = cfg_i.target_volume - vol_q[31:0];
    if (cfg_i.weighting_mode == MODE_VOLUME && in_item_i.level_quantity > room) begin
      take = room;
    end else begin
      take = in_item_i.level_quantity;
    end
    vol_sum = {1'b0, vol_q} + {33'd0, take};
    vol_new = vol_sum[SUM_W] ? '1 : vol_sum[SUM_W-1:0];
    cnt_new = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
    lim_new = (cfg_i.weighting_mode == MODE_DEPTH && cnt_new >= cfg_i.depth_limit)
           || (cfg_i.weighting_mode == MODE_VOLUME
               && vol_new >= {32'd0, cfg_i.target_volume});
    if (!accept) begin
      vol_new = vol_q;
      cnt_new = cnt_q;
      lim_new = lim_q;
    end
  end

  always_comb begin
    vol_d = vol_q;
    cnt_d = cnt_q;
    lim_d = lim_q;
    if (in_fire) begin
      if (in_item_i.last_level) begin
        vol_d = '0;
        cnt_d = '0;
        lim_d = 1'b0;
      end else begin
        vol_d = vol_new;
        cnt_d = cnt_new;
        lim_d = lim_new;
      end
    end
  end

  assign prod = s1_price_q * s1_take_q;

  always_comb begin
    val_sum = {1'b0, val_q} + {2'b00, s2_prod_q};
    val_d   = val_q;
    sat_d   = sat_q;
    if (s2_acc_q) begin
      if (val_sum[SUM_W]) begin
        val_d = '1;
        sat_d = 1'b1;
      end else begin
        val_d = val_sum[SUM_W-1:0];
        sat_d = sat_q | (&val_sum[SUM_W-1:0]);
      end
    end
  end

  assign push_o                  = s2_valid_q & s2_last_q;
  assign push_data_o.value_sum   = val_d;
  assign push_data_o.volume_sum  = s2_vol_q;
  assign push_data_o.level_count = s2_cnt_q;
  assign push_data_o.saturated   = sat_d;
  assign push_data_o.side        = s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q      <= '0;
      cnt_q      <= '0;
      lim_q      <= 1'b0;
      val_q      <= '0;
      sat_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      vol_q      <= vol_d;
      cnt_q      <= cnt_d;
      lim_q      <= lim_d;
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        if (s2_last_q) begin
          val_q <= '0;
          sat_q <= 1'b0;
        end else begin
          val_q <= val_d;
          sat_q <= sat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_acc_q   <= accept;
      s1_last_q  <= in_item_i.last_level;
      s1_side_q  <= in_item_i.book_side;
      s1_price_q <= in_item_i.level_price;
      s1_take_q  <= take;
      s1_vol_q   <= vol_new;
      s1_cnt_q   <= cnt_new;
    end
    if (s1_valid_q) begin
      s2_acc_q  <= s1_acc_q;
      s2_last_q <= s1_last_q;
      s2_side_q <= s1_side_q;
      s2_prod_q <= prod;
      s2_vol_q  <= s1_vol_q;
      s2_cnt_q  <= s1_cnt_q;
    end
  end

endmodule

### hw/rtl/vwap_queue.sv
// short fifo of finished run totals between front end and divider
`timescale 1ns / 1ps

module vwap_queue import vwap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  run_sum_t  push_data_i,
  input  logic      pop_i,
  output run_sum_t  head_o,
  output q_status_t status_o
);

  run_sum_t           entry_q [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0]   level_q;

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.level = level_q;
  assign status_o.empty = (level_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   level_q <= level_q + LVL_W'(1);
        2'b01:   level_q <= level_q - LVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/vwap_divider.sv
// back end: bit-serial fixed point divider and result register
`timescale 1ns / 1ps

module vwap_divider import vwap_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  run_sum_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int QW    = SUM_W + FRAC_BITS;
  localparam int STP_W = $clog2(QW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } div_state_e;

  div_state_e       state_q, state_d;
  logic [QW-1:0]    divd_q;
  logic [SUM_W-1:0] rem_q, den_q;
  logic [STP_W-1:0] step_q;
  logic             dz_q;
  logic [CNT_W-1:0] cnt_q;
  logic             sat_q, side_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic [SUM_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic [AVG_W-1:0] avg;
  logic             out_free;

  // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
  assign rem_sh  = {rem_q, divd_q[QW-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign avg = dz_q                  ? '0 :
               (|divd_q[QW-1:AVG_W]) ? '1 : divd_q[AVG_W-1:0];

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) & ~q_status_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == STP_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      divd_q <= QW'(head_i.value_sum) << FRAC_BITS;
      rem_q  <= '0;
      den_q  <= head_i.volume_sum;
      dz_q   <= (head_i.volume_sum == '0);
      step_q <= STP_W'(QW);
      cnt_q  <= head_i.level_count;
      sat_q  <= head_i.saturated;
      side_q <= head_i.side;
    end else if (state_q == ST_DIV) begin
      divd_q <= {divd_q[QW-2:0], ge};
      rem_q  <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      step_q <= step_q - STP_W'(1);
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.average_price   <= avg;
      out_q.volume_used     <= den_q;
      out_q.levels_used     <= cnt_q;
      out_q.value_saturated <= sat_q;
      out_q.result_side     <= side_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hw/rtl/vwap_accumulator.sv
// top level of the volume weighted average price accumulator
`timescale 1ns / 1ps

// Items (price, quantity, last mark, side) are taken at one per cycle while the
// result queue has room; each run ends with the item marked last and yields one
// result after the front-end pipeline and the divide. The divider handles one run at
// a time, so a stream of short runs is paced by the divider: up to four finished
// runs wait in the queue, after that in_stall_o stays high until a divide completes.
// Configuration writes are always taken (cfg_ready_o is tied high) and apply to
// the next item; write them only while the block is idle.
module vwap_accumulator import vwap_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      push, pop;
  run_sum_t  push_data, head;
  q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:   cfg_d.weighting_mode = cfg_data_i[1:0];
        CFG_DEPTH:  cfg_d.depth_limit    = cfg_data_i[15:0];
        CFG_TARGET: cfg_d.target_volume  = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weighting_mode <= MODE_ALL;
      cfg_q.depth_limit    <= 16'd1;
      cfg_q.target_volume  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vwap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  vwap_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  vwap_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // credit scheme must keep a slot free for every run end in flight
  a_queue_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_status.level != LVL_W'(QDEPTH)))
    else $error("run totals pushed into a full queue");

  a_queue_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_status.level != '0))
    else $error("divider popped an empty queue");

  a_zero_volume_average : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.volume_used == '0) |-> (out_item_o.average_price == '0))
    else $error("nonzero average for a run with no volume");

endmodule

### bench/tb_vwap_accumulator.sv
// testbench of the vwap accumulator: predicts each run's average and checks every result
`timescale 1ns / 1ps

module tb_vwap_accumulator;
  import vwap_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int QUOT_W        = SUM_W + FRAC_BITS;
  localparam int DIV_CYCLES    = 3 + SUM_W + FRAC_BITS + 2;
  localparam int SETTLE_CYCLES = 2 * DIV_CYCLES;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 38;
  localparam int MAX_PRINTS    = 50;

  localparam logic [30:0] PRICE_MAX   = '1;
  localparam logic [31:0] QTY_MAX     = '1;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_BURSTY} rx_pattern_e;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  // predicted run state and register copies
  cfg_t        shadow_cfg;
  logic [63:0] value_acc;
  logic [63:0] volume_acc;
  logic [15:0] count_acc;
  logic        cap_hit;
  logic        sat_seen;
  out_item_t   pending_vwaps[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  bit          gaps_on = 1'b1;
  rx_pattern_e rx_pattern = RX_FREE;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_phase = 0;

  vwap_accumulator #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall pattern; a new hold ticket starts a long hold-off
  always @(posedge clk) begin
    rx_phase <= (rx_phase + 1) % 8;
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (rx_pattern)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        default:  out_stall <= (rx_phase < 5);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vwaps.size() == 0) begin
        report_mismatch("result with no run pending", out_item.volume_used, '0);
      end else begin
        want = pending_vwaps.pop_front();
        if (out_item.average_price !== want.average_price)
          report_mismatch("average_price", 64'(out_item.average_price),
                          64'(want.average_price));
        if (out_item.volume_used !== want.volume_used)
          report_mismatch("volume_used", out_item.volume_used, want.volume_used);
        if (out_item.levels_used !== want.levels_used)
          report_mismatch("levels_used", 64'(out_item.levels_used),
                          64'(want.levels_used));
        if (out_item.value_saturated !== want.value_saturated)
          report_mismatch("value_saturated", 64'(out_item.value_saturated),
                          64'(want.value_saturated));
        if (out_item.result_side !== want.result_side)
          report_mismatch("result_side", 64'(out_item.result_side),
                          64'(want.result_side));
      end
    end
  end

  function automatic void clear_run_totals();
    value_acc  = '0;
    volume_acc = '0;
    count_acc  = '0;
    cap_hit    = 1'b0;
    sat_seen   = 1'b0;
  endfunction

  // value * 2^FRAC_BITS / volume, truncated, clipped to the output width
  function automatic logic [46:0] vwap_of(input logic [63:0] value, input logic [63:0] volume);
    logic [QUOT_W-1:0] quot;
    if (volume == '0)
      return '0;
    quot = {value, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, volume};
    if (quot[QUOT_W-1:47] != '0)
      return '1;
    return quot[46:0];
  endfunction

  function automatic void predict_level(input in_item_t item);
    logic [63:0] take;
    logic [63:0] room;
    logic [63:0] prod;
    logic [64:0] sum;
    logic        accept;
    out_item_t   res;
    take = {32'b0, item.level_quantity};
    if (cap_hit)
      accept = 1'b0;
    else if (shadow_cfg.weighting_mode == MODE_DEPTH)
      accept = count_acc < shadow_cfg.depth_limit;
    else if (shadow_cfg.weighting_mode == MODE_VOLUME)
      accept = volume_acc < {32'b0, shadow_cfg.target_volume};
    else
      accept = 1'b1;
    if (accept) begin
      if (shadow_cfg.weighting_mode == MODE_VOLUME) begin
        room = {32'b0, shadow_cfg.target_volume} - volume_acc;
        if (take > room)
          take = room;
      end
      prod = {33'b0, item.level_price} * take;
      sum = {1'b0, value_acc} + {1'b0, prod};
      if (sum[64] || sum[63:0] == '1) begin
        value_acc = '1;
        sat_seen  = 1'b1;
      end else begin
        value_acc = sum[63:0];
      end
      sum = {1'b0, volume_acc} + {1'b0, take};
      volume_acc = sum[64] ? '1 : sum[63:0];
      if (count_acc != '1)
        count_acc++;
      if (shadow_cfg.weighting_mode == MODE_DEPTH && count_acc >= shadow_cfg.depth_limit)
        cap_hit = 1'b1;
      if (shadow_cfg.weighting_mode == MODE_VOLUME &&
          volume_acc >= {32'b0, shadow_cfg.target_volume})
        cap_hit = 1'b1;
    end
    if (item.last_level) begin
      res.average_price   = vwap_of(value_acc, volume_acc);
      res.volume_used     = volume_acc;
      res.levels_used     = count_acc;
      res.value_saturated = sat_seen;
      res.result_side     = item.book_side;
      pending_vwaps.push_back(res);
      clear_run_totals();
    end
  endfunction

  function automatic in_item_t make_level(input logic [30:0] price, input logic [31:0] qty,
                                          input logic last, input logic side);
    in_item_t item;
    item.level_price    = price;
    item.level_quantity = qty;
    item.last_level     = last;
    item.book_side      = side;
    return item;
  endfunction

  // offers one item, keeps it stable until taken, then maybe opens a gap
  task automatic send_level(input in_item_t item);
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_level(item);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_run(input int length, input bit small_qty, input bit small_price);
    in_item_t item;
    for (int i = 0; i < length; i++) begin
      item.level_price    = small_price ? 31'($urandom_range(0, 5000)) : 31'($urandom);
      item.level_quantity = small_qty ? 32'($urandom_range(0, 300)) : 32'($urandom);
      item.last_level     = (i == length - 1);
      item.book_side      = 1'($urandom_range(0, 1));
      send_level(item);
    end
  endtask

  task automatic wait_idle();
    if (in_valid)
      in_valid <= 1'b0;
    while (pending_vwaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [15:0] depth,
                           input logic [31:0] target);
    wait_idle();
    put_reg(CFG_MODE, {30'b0, mode});
    put_reg(CFG_DEPTH, {16'b0, depth});
    put_reg(CFG_TARGET, target);
    cfg_valid <= 1'b0;
    shadow_cfg.weighting_mode = mode;
    shadow_cfg.depth_limit    = depth;
    shadow_cfg.target_volume  = target;
  endtask

  // runs with the register values left by reset
  task automatic test_reset_registers();
    send_level(make_level('0, QTY_MAX, 1'b0, 1'b0));
    send_level(make_level(PRICE_MAX, 32'd1, 1'b0, 1'b1));
    send_level(make_level(31'd12345, 32'd7, 1'b1, 1'b1));
    // zero volume run
    send_level(make_level(PRICE_MAX, '0, 1'b1, 1'b0));
  endtask

  task automatic test_value_saturation();
    repeat (3) send_level(make_level(PRICE_MAX, QTY_MAX, 1'b0, 1'b0));
    send_level(make_level(PRICE_MAX, QTY_MAX, 1'b1, 1'b1));
  endtask

  task automatic test_depth_limit();
    configure(MODE_DEPTH, 16'd2, 32'd0);
    send_level(make_level(31'd100, 32'd10, 1'b0, 1'b1));
    send_level(make_level(31'd200, 32'd30, 1'b0, 1'b0));
    send_level(make_level(31'd900, 32'd50, 1'b0, 1'b1));
    send_level(make_level(31'd700, 32'd5, 1'b1, 1'b1));
    configure(MODE_DEPTH, 16'd0, QTY_MAX);
    send_level(make_level(31'd55, 32'd3, 1'b0, 1'b0));
    send_level(make_level(31'd66, 32'd4, 1'b1, 1'b0));
    configure(MODE_DEPTH, 16'hFFFF, 32'd0);
    send_level(make_level(PRICE_MAX, QTY_MAX, 1'b1, 1'b1));
  endtask

  task automatic test_volume_target();
    configure(MODE_VOLUME, 16'd1, 32'd100);
    send_level(make_level(31'd1000, 32'd60, 1'b0, 1'b1));
    send_level(make_level(31'd1010, 32'd60, 1'b0, 1'b1));
    send_level(make_level(31'd1020, 32'd30, 1'b1, 1'b0));
    configure(MODE_VOLUME, 16'd1, 32'd0);
    send_level(make_level(31'd500, 32'd8, 1'b1, 1'b1));
    configure(MODE_VOLUME, 16'hFFFF, QTY_MAX);
    send_level(make_level(PRICE_MAX, QTY_MAX, 1'b0, 1'b0));
    send_level(make_level(31'd1, QTY_MAX, 1'b1, 1'b0));
  endtask

  // the unused mode code weights every item
  task automatic test_unused_mode();
    configure(MODE_UNUSED, 16'd1, 32'd1);
    send_level(make_level(31'd300, 32'd9, 1'b0, 1'b1));
    send_level(make_level(31'd301, 32'd11, 1'b1, 1'b1));
  endtask

  // short runs against a held-off receiver fill the result queue
  task automatic test_result_backlog();
    configure(MODE_ALL, 16'd1, 32'd0);
    rx_pattern <= RX_FREE;
    gaps_on = 1'b0;
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 30; i++)
      send_run($urandom_range(1, 2), 1'b1, 1'b1);
    // sender pause until every result is out
    if (in_valid)
      in_valid <= 1'b0;
    while (pending_vwaps.size() != 0) @(posedge clk);
    rx_pattern <= RX_HALF;
    gaps_on = 1'b1;
    for (int i = 0; i < 10; i++)
      send_run($urandom_range(1, 3), 1'b0, 1'b0);
  endtask

  task automatic test_random_runs();
    int          sent;
    int          len;
    bit          small_qty;
    bit          small_price;
    logic [1:0]  mode;
    logic [15:0] depth;
    logic [31:0] target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       depth = '0;
        1:       depth = '1;
        2:       depth = 16'd1;
        default: depth = 16'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 3))
        0:       target = '0;
        1:       target = '1;
        2:       target = 32'($urandom_range(1, 2000));
        default: target = $urandom;
      endcase
      configure(mode, depth, target);
      rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      small_qty = 1'($urandom_range(0, 1));
      small_price = 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        send_run(len, small_qty, small_price);
        sent += len;
      end
    end
  endtask

  initial begin
    shadow_cfg.weighting_mode = MODE_ALL;
    shadow_cfg.depth_limit    = 16'd1;
    shadow_cfg.target_volume  = '0;
    clear_run_totals();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_registers();
    test_value_saturation();
    test_depth_limit();
    test_volume_target();
    test_unused_mode();
    test_result_backlog();
    test_random_runs();
    wait_idle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/vwap_pkg.sv
hw/rtl/vwap_front.sv
hw/rtl/vwap_queue.sv
hw/rtl/vwap_divider.sv
hw/rtl/vwap_accumulator.sv
bench/tb_vwap_accumulator.sv
